FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the byte packer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define AST_HOLDS(label, clk, rst_n, prop)
`define AST_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: sv/w36bp_pkg.sv
// ----------------------------------------------------------------------------
// Byte packer package
// Types, widths and format codes shared by the 36-bit word byte packer.
// ----------------------------------------------------------------------------
package w36bp_pkg;

	localparam int unsigned WORD_W        = 36;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned JOB_BYTES     = 9;
	localparam int unsigned JOB_W         = JOB_BYTES * BYTE_W;
	localparam int unsigned LEN_W         = 4;
	localparam int unsigned W36BP_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FMT_LE64 = 2'd0,
		FMT_BE64 = 2'd1,
		FMT_CORE = 2'd2,
		FMT_PAIR = 2'd3
	} fmt_t;

	// One word's worth of output: bytes in stream order, first byte in the top bits.
	typedef struct packed {
		logic [JOB_W-1:0] data;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

FILE: sv/word36_byte_packer.sv
// With the serializer idle, an accepted word is first written into a queue entry,
// then loaded into the output register, which then shows its first byte.
// Throughput: one output byte per cycle while out_ready is high; a word is 8 bytes
// in the 64-bit formats, 5 in core dump, and 4, 5 or 9 in nine-byte pairs.
// Words are taken while earlier bytes still drain, up to the queue depth.
// Reset (asynchronous, active low) sets little-endian format, clears the open
// pair, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
// 36-bit word byte packer
// Packs 36-bit words into a byte stream in one of four selectable formats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module word36_byte_packer import w36bp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = W36BP_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [1:0]        cfg_write_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] word_value,
	input  logic              last_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              end_of_run
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head_job;

	w36bp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.word_value     (word_value),
		.last_word      (last_word),
		.q_stat         (q_stat),
		.push           (push),
		.push_job       (push_job)
	);

	w36bp_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	w36bp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.end_of_run (end_of_run)
	);

	// A transfer that is not the final byte of a word leaves more bytes to send.
	`AST_HOLDS(a_run_continues, clk, arst_n, (out_valid && out_ready && !end_of_run) |=> out_valid)
	// The output only goes idle after the final byte of a word transfers.
	`AST_HOLDS(a_idle_after_end, clk, arst_n, $fell(out_valid) |-> $past(end_of_run && out_ready))
	// The serializer never pulls from an empty queue.
	`AST_NEVER(a_no_underflow, clk, arst_n, pop && q_stat.empty)

endmodule

FILE: sv/w36bp_front.sv
// ----------------------------------------------------------------------------
// Byte packer front end
// Holds the format register and pair state, and turns each accepted word
// into a job: the byte sequence it produces and its length.
// ----------------------------------------------------------------------------
module w36bp_front import w36bp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [1:0]        cfg_write_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] word_value,
	input  logic              last_word,
	input  q_stat_t           q_stat,
	output logic              push,
	output job_t              push_job
);

	fmt_t       fmt_q;
	logic [3:0] held_q;
	logic       second_q;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_job = '0;
		unique case (fmt_q)
			FMT_LE64: begin
				push_job.data = {word_value[7:0], word_value[15:8], word_value[23:16],
					word_value[31:24], 4'h0, word_value[35:32], 32'h0};
				push_job.len  = LEN_W'(8);
			end
			FMT_BE64: begin
				push_job.data = {24'h0, 4'h0, word_value[35:32], word_value[31:0], 8'h00};
				push_job.len  = LEN_W'(8);
			end
			FMT_CORE: begin
				push_job.data = {word_value[35:4], 4'h0, word_value[3:0], 32'h0};
				push_job.len  = LEN_W'(5);
			end
			FMT_PAIR: begin
				if (!second_q) begin
					if (last_word) begin
						// A lone first word flushes the shared byte and four zero bytes.
						push_job.data = {word_value[35:4], word_value[3:0], 4'h0, 32'h0};
						push_job.len  = LEN_W'(9);
					end else begin
						push_job.data = {word_value[35:4], 40'h0};
						push_job.len  = LEN_W'(4);
					end
				end else begin
					push_job.data = {held_q, word_value[35:32], word_value[31:0], 32'h0};
					push_job.len  = LEN_W'(5);
				end
			end
			default: begin
				push_job = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_LE64;
			held_q   <= '0;
			second_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				fmt_q <= fmt_t'(cfg_write_data);
			end
			if (push && fmt_q == FMT_PAIR) begin
				if (!second_q && !last_word) begin
					held_q   <= word_value[3:0];
					second_q <= 1'b1;
				end else begin
					held_q   <= '0;
					second_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: sv/w36bp_queue.sv
// ----------------------------------------------------------------------------
// Byte packer job queue
// Short FIFO of jobs between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module w36bp_queue import w36bp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = W36BP_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head_job,
	output q_stat_t q_stat
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign head_job     = entry_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/w36bp_back.sv
// ----------------------------------------------------------------------------
// Byte packer serializer
// Loads one job at a time and shifts its bytes out on the output channel.
// ----------------------------------------------------------------------------
module w36bp_back import w36bp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_stat_t           q_stat,
	input  job_t              head_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              end_of_run
);

	logic             valid_q;
	logic [JOB_W-1:0] shift_q;
	logic [LEN_W-1:0] left_q;
	logic             xfer;
	logic             last_xfer;

	assign out_valid  = valid_q;
	assign out_byte   = shift_q[JOB_W-1 -: BYTE_W];
	assign end_of_run = (left_q == LEN_W'(1));
	assign xfer       = valid_q && out_ready;
	assign last_xfer  = xfer && end_of_run;
	// When the queue is not empty, the next job loads in the same cycle the final byte of the current one transfers.
	assign pop        = !q_stat.empty && (!valid_q || last_xfer);

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= head_job.data;
		end else if (xfer) begin
			shift_q <= {shift_q[JOB_W-BYTE_W-1:0], BYTE_W'(0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				left_q  <= head_job.len;
			end else if (last_xfer) begin
				valid_q <= 1'b0;
				left_q  <= '0;
			end else if (xfer) begin
				left_q  <= left_q - LEN_W'(1);
			end
		end
	end

endmodule
